// ===== design/slpe_pkg.sv =====
// Shared types and constants for the slot pool with oldest-slot eviction.
package slpe_pkg;

  // Width of slot numbers on the ports
  localparam int unsigned SLOT_W = 11;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Write enables toward the link memories
  typedef struct packed {
    logic we_next;
    logic we_prev;
    logic we_act;
    logic act_data;
  } wr_ctl_t;

  // One result beat
  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              evicted;
    logic [SLOT_W-1:0] evicted_slot;
    logic              status;
  } res_t;

endpackage

// ===== design/slpe_links.sv =====
// Link memories of the pool: next link, prev link and active mark per slot.
module slpe_links import slpe_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 2048
) (
  input  logic                            clk,
  input  logic [$clog2(SLOT_COUNT)-1:0]   rd_addr,
  input  wr_ctl_t                         wr_ctl,
  input  logic [$clog2(SLOT_COUNT)-1:0]   next_addr,
  input  logic [$clog2(SLOT_COUNT+1)-1:0] next_data,
  input  logic [$clog2(SLOT_COUNT)-1:0]   prev_addr,
  input  logic [$clog2(SLOT_COUNT+1)-1:0] prev_data,
  input  logic [$clog2(SLOT_COUNT)-1:0]   act_addr,
  output logic [$clog2(SLOT_COUNT+1)-1:0] rd_next,
  output logic [$clog2(SLOT_COUNT+1)-1:0] rd_prev,
  output logic                            rd_act
);

  localparam int unsigned LW = $clog2(SLOT_COUNT + 1);

  logic [LW-1:0] next_mem [SLOT_COUNT];
  logic [LW-1:0] prev_mem [SLOT_COUNT];
  logic          act_mem  [SLOT_COUNT];

  // Next-link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_ctl.we_next) begin
      next_mem[next_addr] <= next_data;
    end
    rd_next <= next_mem[rd_addr];
  end

  // Prev-link memory
  always_ff @(posedge clk) begin
    if (wr_ctl.we_prev) begin
      prev_mem[prev_addr] <= prev_data;
    end
    rd_prev <= prev_mem[rd_addr];
  end

  // Active marks
  always_ff @(posedge clk) begin
    if (wr_ctl.we_act) begin
      act_mem[act_addr] <= wr_ctl.act_data;
    end
    rd_act <= act_mem[rd_addr];
  end

endmodule

// ===== design/slpe_seq.sv =====
// Sequencer: walks one allocate or release through the link memories.
module slpe_seq import slpe_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              opcode,
  input  logic [SLOT_W-1:0] slot_in,
  output logic              idle,
  input  logic              out_free,
  output logic              done_valid,
  output res_t              res
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned LW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CW = (LW > SLOT_W) ? LW : SLOT_W;
  localparam logic [LW-1:0] NONE = LW'(SLOT_COUNT);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RLOOK = 6'b000010,
    ST_RPUSH = 6'b000100,
    ST_PLINK = 6'b001000,
    ST_PFIN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [LW-1:0]     cur, cur_next;          // slot being worked on
  logic [LW-1:0]     fill, fill_next;        // slots below this were ever handed out
  logic [LW-1:0]     free_top, free_top_next;
  logic [LW-1:0]     newest, newest_next;
  logic [LW-1:0]     oldest, oldest_next;
  logic              nf_known, nf_known_next;
  logic [LW-1:0]     nf, nf_next;
  logic              evict, evict_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic              res_status, res_status_next;

  // Memory interface
  logic [IW-1:0] rd_addr;
  wr_ctl_t       wr_ctl;
  logic [IW-1:0] next_addr, prev_addr, act_addr;
  logic [LW-1:0] next_data, prev_data;
  logic [LW-1:0] rd_next, rd_prev;
  logic          rd_act;

  logic [CW-1:0] slot_w;
  logic [CW-1:0] cur_w;
  logic          in_range;

  assign slot_w   = CW'(slot_in);
  assign cur_w    = CW'(cur);
  assign in_range = slot_w < CW'(fill);
  assign idle     = (state == ST_IDLE);

  slpe_links #(.SLOT_COUNT(SLOT_COUNT)) u_links (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .wr_ctl    (wr_ctl),
    .next_addr (next_addr),
    .next_data (next_data),
    .prev_addr (prev_addr),
    .prev_data (prev_data),
    .act_addr  (act_addr),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev),
    .rd_act    (rd_act)
  );

  // Read address: release slot, else free-stack top, else oldest slot
  always_comb begin
    if (opcode == OP_RELEASE) begin
      rd_addr = slot_w[IW-1:0];
    end else if (free_top != NONE) begin
      rd_addr = free_top[IW-1:0];
    end else begin
      rd_addr = oldest[IW-1:0];
    end
  end

  // Next-state and memory write control
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    fill_next       = fill;
    free_top_next   = free_top;
    newest_next     = newest;
    oldest_next     = oldest;
    nf_known_next   = nf_known;
    nf_next         = nf;
    evict_next      = evict;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    wr_ctl          = '0;
    next_addr       = cur[IW-1:0];
    prev_addr       = cur[IW-1:0];
    act_addr        = cur[IW-1:0];
    next_data       = free_top;
    prev_data       = NONE;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          evict_next      = 1'b0;
          res_status_next = STATUS_OK;
          if (opcode == OP_RELEASE) begin
            res_slot_next = slot_in;
            if (in_range) begin
              cur_next   = slot_w[LW-1:0];
              state_next = ST_RLOOK;
            end else begin
              res_status_next = STATUS_REFUSED;
              state_next      = ST_DONE;
            end
          end else if (free_top != NONE) begin
            // pop; a never-used slot on top chains to the one after it
            cur_next = free_top;
            if (free_top == fill) begin
              nf_known_next = 1'b1;
              nf_next       = fill + 1'b1;
              fill_next     = fill + 1'b1;
            end else begin
              nf_known_next = 1'b0;
            end
            state_next = ST_PLINK;
          end else if (oldest != NONE) begin
            cur_next   = oldest;
            evict_next = 1'b1;
            state_next = ST_RLOOK;
          end else begin
            res_slot_next = '0;
            state_next    = ST_DONE;
          end
        end
      end

      ST_RLOOK: begin
        // unlink: rd_prev is the newer neighbor, rd_next the older one
        if (!rd_act) begin
          res_status_next = STATUS_REFUSED;
          state_next      = ST_DONE;
        end else begin
          next_addr       = rd_prev[IW-1:0];
          next_data       = rd_next;
          wr_ctl.we_next  = (rd_prev != NONE);
          prev_addr       = rd_next[IW-1:0];
          prev_data       = rd_prev;
          wr_ctl.we_prev  = (rd_next != NONE);
          wr_ctl.we_act   = 1'b1;
          wr_ctl.act_data = 1'b0;
          if (rd_prev == NONE) begin
            newest_next = rd_next;
          end
          if (rd_next == NONE) begin
            oldest_next = rd_prev;
          end
          if (evict) begin
            // the reclaimed slot is popped again at once; stack stays empty
            nf_known_next = 1'b1;
            nf_next       = NONE;
            state_next    = ST_PLINK;
          end else begin
            state_next = ST_RPUSH;
          end
        end
      end

      ST_RPUSH: begin
        wr_ctl.we_next = 1'b1;
        next_data      = free_top;
        free_top_next  = cur;
        state_next     = ST_DONE;
      end

      ST_PLINK: begin
        // link in as newest
        free_top_next   = nf_known ? nf : rd_next;
        wr_ctl.we_next  = 1'b1;
        next_data       = newest;
        wr_ctl.we_act   = 1'b1;
        wr_ctl.act_data = 1'b1;
        prev_addr       = newest[IW-1:0];
        prev_data       = cur;
        wr_ctl.we_prev  = (newest != NONE);
        if (newest == NONE) begin
          oldest_next = cur;
        end
        newest_next   = cur;
        res_slot_next = cur_w[SLOT_W-1:0];
        state_next    = ST_PFIN;
      end

      ST_PFIN: begin
        wr_ctl.we_prev = 1'b1;
        prev_data      = NONE;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      free_top <= '0;
      newest   <= NONE;
      oldest   <= NONE;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      free_top <= free_top_next;
      newest   <= newest_next;
      oldest   <= oldest_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    nf_known   <= nf_known_next;
    nf         <= nf_next;
    evict      <= evict_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
  end

  // Result beat
  assign done_valid       = (state == ST_DONE);
  assign res.slot_out     = res_slot;
  assign res.evicted      = evict;
  assign res.evicted_slot = evict ? res_slot : '0;
  assign res.status       = res_status;

endmodule

// ===== design/slot_pool_oldest_eviction_top.sv =====
// Top level of the slot pool allocator with oldest-slot eviction.
//
//   channel | direction | handshake          | beat fields
//   --------+-----------+--------------------+--------------------------------------
//   in      | in        | in_valid/in_stall  | opcode, slot_in
//   out     | out       | out_valid/out_stall| slot_out, evicted, evicted_slot, status
//
// One item at a time; each link memory takes one read and one write per cycle,
// so from IDLE an item walks dependent link accesses: allocate PLINK, PFIN, DONE
// (eviction: RLOOK first); release RLOOK, RPUSH, DONE; refused release goes to DONE
// at once or after RLOOK. Reset: no clearing pass, a fill mark tracks untouched slots.
// The sequencer holds its result while the output register is full and stalled.
module slot_pool_oldest_eviction_top import slpe_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [SLOT_W-1:0] slot_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] slot_out,
  output logic              evicted,
  output logic [SLOT_W-1:0] evicted_slot,
  output logic              status
);

  logic idle;
  logic out_free;
  logic done_valid;
  res_t res;
  res_t out_reg;

  assign in_stall = !idle;
  assign out_free = !out_valid || !out_stall;

  slpe_seq #(.SLOT_COUNT(SLOT_COUNT)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .opcode     (opcode),
    .slot_in    (slot_in),
    .idle       (idle),
    .out_free   (out_free),
    .done_valid (done_valid),
    .res        (res)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= done_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_free && done_valid) begin
      out_reg <= res;
    end
  end

  assign slot_out     = out_reg.slot_out;
  assign evicted      = out_reg.evicted;
  assign evicted_slot = out_reg.evicted_slot;
  assign status       = out_reg.status;

endmodule

// ===== design/slpe_chk.sv =====
// Port-level checks for the slot pool top level, with its bind.
module slpe_chk import slpe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SLOT_W-1:0] slot_out,
  input logic              evicted,
  input logic [SLOT_W-1:0] evicted_slot,
  input logic              status
);

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot_out) && $stable(status))
    else $error("result beat changed under stall");

  // An eviction hands the reclaimed slot straight back out, with ok status
  a_evict_reuse: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> (slot_out == evicted_slot) && (status == STATUS_OK))
    else $error("eviction result inconsistent");

  // Without eviction the reclaimed-slot field is zero
  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_slot == '0)
    else $error("evicted_slot set without eviction");

  // Taking an item makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took an item but was not busy after");

endmodule

bind slot_pool_oldest_eviction_top slpe_chk u_slpe_chk (.*);
